// ----- rtl/core/ldist_pkg.sv -----
// Shared types, register indexes and saturation helpers for lens_distortion_apply.
// Used by ldist_cfg, ldist_fmul and the lens_distortion_apply top level.
`timescale 1ns / 1ps

package ldist_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 32;
  localparam int WIDE_W    = 64;
  // Holds 2*a + b for two 32-bit terms
  localparam int TAN_W     = 34;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2   = 3'd4;

  localparam logic [1:0] MODE_RADIAL1 = 2'd0;

  localparam logic signed [WIDE_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  k1;
    logic signed [COORD_W-1:0]  k2;
    logic signed [COORD_W-1:0]  p1;
    logic signed [COORD_W-1:0]  p2;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] value;
    logic                      sat;
  } sat_t;

  function automatic sat_t sat64(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    if (x > S32_MAX) begin
      r.value = COORD_W'(S32_MAX);
      r.sat   = 1'b1;
    end else if (x < S32_MIN) begin
      r.value = COORD_W'(S32_MIN);
      r.sat   = 1'b1;
    end else begin
      r.value = COORD_W'(x);
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sx64(input logic signed [COORD_W-1:0] x);
    return WIDE_W'(x);
  endfunction

endpackage

// ----- rtl/core/ldist_cfg.sv -----
// Configuration register file for lens_distortion_apply.
// Depends on ldist_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module ldist_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ldist_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldist_pkg::COORD_W-1:0]    cfg_data,
  output ldist_pkg::cfg_t                  cfg
);
  import ldist_pkg::*;

  assign cfg_ready = 1'b1;

  // Drop writes to indexes past the last register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: cfg.mode <= cfg_data[1:0];
        REG_K1:   cfg.k1   <= cfg_data;
        REG_K2:   cfg.k2   <= cfg_data;
        REG_P1:   cfg.p1   <= cfg_data;
        REG_P2:   cfg.p2   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/ldist_fmul.sv -----
// Two-stage fixed-point multiplier: registered 32x32 product, then
// round-to-nearest, shift by FRAC_BITS and saturate. Depends on ldist_pkg.
`timescale 1ns / 1ps

module ldist_fmul #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 en_mul,
  input  logic                                 en_rnd,
  input  logic signed [ldist_pkg::COORD_W-1:0] a,
  input  logic signed [ldist_pkg::COORD_W-1:0] b,
  output ldist_pkg::sat_t                      res
);
  import ldist_pkg::*;

  localparam logic signed [WIDE_W-1:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [WIDE_W-1:0] prod;
  logic signed [WIDE_W-1:0] rounded;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= sx64(a) * sx64(b);
    end
  end

  // Ties round toward plus infinity
  always_comb begin
    rounded = (prod + HALF) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en_rnd) begin
      res <= sat64(rounded);
    end
  end

endmodule

// ----- rtl/core/lens_distortion_apply.sv -----
// Brown-Conrady lens distortion: radial and tangential terms applied to a
// normalized point. Depends on ldist_pkg, ldist_cfg and ldist_fmul.
//
// Usage:
//   Slave stream s_*: one point per transaction, s_tdata = {point_v, point_u}.
//   Master stream m_*: one result per point, m_tdata = {distorted_v,
//   distorted_u}, m_tuser = saturated_flag (any clip in a term that the mode uses).
//   Config channel cfg_*: cfg_index selects model_mode, radial_k1, radial_k2,
//   tangential_p1, tangential_p2 (0..4); other indexes are ignored. Write
//   only while no point is in flight. cfg_ready is always high.
// The pipeline depth is set by four dependent multiply rounds (squares,
// k1*r2 and k2*r2, (k2*r2)*r2 with the tangential products, then u*radial),
// each a registered product plus a registered round/saturate stage, and the
// adds and clips between them.
// Throughput: one point per cycle while the receiver accepts; every stage
// advances independently, so bubbles close up when the receiver stalls and
// nothing is lost or repeated.
// Reset: rst clears all valid bits and sets every configuration register to
// zero (mode 0).
`timescale 1ns / 1ps

module lens_distortion_apply #(
  parameter int FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // [31:0] point_u, [63:32] point_v
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,   // [31:0] distorted_u, [63:32] distorted_v
  output logic                            m_tuser,   // [0] saturated_flag
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ldist_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldist_pkg::COORD_W-1:0]   cfg_data
);
  import ldist_pkg::*;

  localparam int NSTG = 12;

  cfg_t cfg;
  logic mode_nz;
  logic mode_tan;

  logic [NSTG:1] vld;
  logic [NSTG:1] rdy;

  logic signed [COORD_W-1:0] in_u, in_v;

  // stage payloads
  logic signed [COORD_W-1:0] s1_u, s1_v, s2_u, s2_v;
  logic signed [COORD_W-1:0] s3_u, s3_v, s3_u2, s3_v2, s3_uv, s3_r2;
  logic                      s3_flag;
  logic signed [COORD_W-1:0] s4_u, s4_v, s4_uv, s4_r2, s4_ru, s4_rv;
  logic                      s4_flag;
  logic signed [COORD_W-1:0] s5_u, s5_v, s5_uv, s5_r2, s5_ru, s5_rv;
  logic                      s5_flag;
  logic signed [COORD_W-1:0] s6_u, s6_v, s6_k1r2;
  logic                      s6_flag;
  logic signed [COORD_W-1:0] s7_u, s7_v, s7_k1r2;
  logic                      s7_flag;
  logic signed [COORD_W-1:0] s8_u, s8_v, s8_radial;
  logic signed [TAN_W-1:0]   s8_tu, s8_tv;
  logic                      s8_flag;
  logic signed [COORD_W-1:0] s9_u, s9_v;
  logic signed [TAN_W-1:0]   s9_tu, s9_tv;
  logic                      s9_flag;
  logic signed [COORD_W-1:0] s10_u, s10_v;
  logic signed [TAN_W-1:0]   s10_tu, s10_tv;
  logic                      s10_flag;
  logic signed [COORD_W-1:0] s11_u, s11_v, s11_du, s11_dv;
  logic                      s11_flag;
  logic signed [COORD_W-1:0] s12_u, s12_v;
  logic                      s12_flag;

  sat_t m_u2, m_v2, m_uv, m_k1r2, m_t, m_tr, m_a, m_b, m_c, m_d, m_du, m_dv;
  sat_t r2_s, ru_s, rv_s, rad_s, du_s, dv_s, ou_s, ov_s;

  assign in_u     = s_tdata[31:0];
  assign in_v     = s_tdata[63:32];
  assign mode_nz  = (cfg.mode != MODE_RADIAL1);
  assign mode_tan = cfg.mode[1];

  ldist_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Each stage loads when empty or when the next stage takes its contents
  always_comb begin
    rdy[NSTG] = !vld[NSTG] || m_tready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Squares and cross product: stages 1-2
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (
    .clk(clk), .en_mul(rdy[1]), .en_rnd(rdy[2]), .a(in_u), .b(in_u), .res(m_u2));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_vv (
    .clk(clk), .en_mul(rdy[1]), .en_rnd(rdy[2]), .a(in_v), .b(in_v), .res(m_v2));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_uv (
    .clk(clk), .en_mul(rdy[1]), .en_rnd(rdy[2]), .a(in_u), .b(in_v), .res(m_uv));

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_u <= in_u;
      s1_v <= in_v;
    end
    if (rdy[2]) begin
      s2_u <= s1_u;
      s2_v <= s1_v;
    end
  end

  // Stage 3: r2
  assign r2_s = sat64(sx64(m_u2.value) + sx64(m_v2.value));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_u    <= s2_u;
      s3_v    <= s2_v;
      s3_u2   <= m_u2.value;
      s3_v2   <= m_v2.value;
      s3_uv   <= m_uv.value;
      s3_r2   <= r2_s.value;
      s3_flag <= m_u2.sat | m_v2.sat | r2_s.sat | (mode_tan & m_uv.sat);
    end
  end

  // Stage 4-5: k1*r2, k2*r2 and the tangential r2 + 2*u2, r2 + 2*v2
  assign ru_s = sat64(sx64(s3_r2) + (sx64(s3_u2) <<< 1));
  assign rv_s = sat64(sx64(s3_r2) + (sx64(s3_v2) <<< 1));

  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_k1 (
    .clk(clk), .en_mul(rdy[4]), .en_rnd(rdy[5]), .a(cfg.k1), .b(s3_r2), .res(m_k1r2));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_k2 (
    .clk(clk), .en_mul(rdy[4]), .en_rnd(rdy[5]), .a(cfg.k2), .b(s3_r2), .res(m_t));

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_u    <= s3_u;
      s4_v    <= s3_v;
      s4_uv   <= s3_uv;
      s4_r2   <= s3_r2;
      s4_ru   <= ru_s.value;
      s4_rv   <= rv_s.value;
      s4_flag <= s3_flag | (mode_tan & (ru_s.sat | rv_s.sat));
    end
    if (rdy[5]) begin
      s5_u    <= s4_u;
      s5_v    <= s4_v;
      s5_uv   <= s4_uv;
      s5_r2   <= s4_r2;
      s5_ru   <= s4_ru;
      s5_rv   <= s4_rv;
      s5_flag <= s4_flag;
    end
  end

  // Stages 6-7: (k2*r2)*r2 and the four tangential products
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_tr (
    .clk(clk), .en_mul(rdy[6]), .en_rnd(rdy[7]), .a(m_t.value), .b(s5_r2), .res(m_tr));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
    .clk(clk), .en_mul(rdy[6]), .en_rnd(rdy[7]), .a(cfg.p1), .b(s5_uv), .res(m_a));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
    .clk(clk), .en_mul(rdy[6]), .en_rnd(rdy[7]), .a(cfg.p2), .b(s5_ru), .res(m_b));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c (
    .clk(clk), .en_mul(rdy[6]), .en_rnd(rdy[7]), .a(cfg.p2), .b(s5_uv), .res(m_c));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_d (
    .clk(clk), .en_mul(rdy[6]), .en_rnd(rdy[7]), .a(cfg.p1), .b(s5_rv), .res(m_d));

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_u    <= s5_u;
      s6_v    <= s5_v;
      s6_k1r2 <= m_k1r2.value;
      s6_flag <= s5_flag | m_k1r2.sat | (mode_nz & m_t.sat);
    end
    if (rdy[7]) begin
      s7_u    <= s6_u;
      s7_v    <= s6_v;
      s7_k1r2 <= s6_k1r2;
      s7_flag <= s6_flag;
    end
  end

  // Stage 8: radial term and tangential offsets
  assign rad_s = sat64(sx64(s7_k1r2) + sx64(m_tr.value));

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_u      <= s7_u;
      s8_v      <= s7_v;
      s8_radial <= mode_nz ? rad_s.value : s7_k1r2;
      if (mode_tan) begin
        s8_tu <= TAN_W'((sx64(m_a.value) <<< 1) + sx64(m_b.value));
        s8_tv <= TAN_W'((sx64(m_c.value) <<< 1) + sx64(m_d.value));
      end else begin
        s8_tu <= '0;
        s8_tv <= '0;
      end
      s8_flag <= s7_flag | (mode_nz & (m_tr.sat | rad_s.sat))
               | (mode_tan & (m_a.sat | m_b.sat | m_c.sat | m_d.sat));
    end
  end

  // Stages 9-10: u*radial, v*radial
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_du (
    .clk(clk), .en_mul(rdy[9]), .en_rnd(rdy[10]), .a(s8_u), .b(s8_radial), .res(m_du));
  ldist_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dv (
    .clk(clk), .en_mul(rdy[9]), .en_rnd(rdy[10]), .a(s8_v), .b(s8_radial), .res(m_dv));

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_u    <= s8_u;
      s9_v    <= s8_v;
      s9_tu   <= s8_tu;
      s9_tv   <= s8_tv;
      s9_flag <= s8_flag;
    end
    if (rdy[10]) begin
      s10_u    <= s9_u;
      s10_v    <= s9_v;
      s10_tu   <= s9_tu;
      s10_tv   <= s9_tv;
      s10_flag <= s9_flag;
    end
  end

  // Stage 11: total offsets
  assign du_s = sat64(sx64(m_du.value) + WIDE_W'(s10_tu));
  assign dv_s = sat64(sx64(m_dv.value) + WIDE_W'(s10_tv));

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      s11_u    <= s10_u;
      s11_v    <= s10_v;
      s11_du   <= du_s.value;
      s11_dv   <= dv_s.value;
      s11_flag <= s10_flag | m_du.sat | m_dv.sat | du_s.sat | dv_s.sat;
    end
  end

  // Stage 12: output register
  assign ou_s = sat64(sx64(s11_u) + sx64(s11_du));
  assign ov_s = sat64(sx64(s11_v) + sx64(s11_dv));

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      s12_u    <= ou_s.value;
      s12_v    <= ov_s.value;
      s12_flag <= s11_flag | ou_s.sat | ov_s.sat;
    end
  end

  assign m_tdata = {s12_v, s12_u};
  assign m_tuser = s12_flag;

endmodule
